// ----- rtl/core/pse_pkg.sv -----
`default_nettype none
package pse_pkg;

    localparam int WORD_W = 32;
    localparam int OP_W   = 4;
    localparam int ST_W   = 2;

    typedef logic [OP_W-1:0] t_op;
    typedef logic [ST_W-1:0] t_status;
    typedef logic [WORD_W-1:0] t_word;

    localparam t_op OP_PUSH = 4'd0;
    localparam t_op OP_ADD  = 4'd1;
    localparam t_op OP_SUB  = 4'd2;
    localparam t_op OP_MUL  = 4'd3;
    localparam t_op OP_DIV  = 4'd4;
    localparam t_op OP_EQ   = 4'd5;
    localparam t_op OP_NE   = 4'd6;
    localparam t_op OP_LT   = 4'd7;
    localparam t_op OP_GT   = 4'd8;
    localparam t_op OP_LE   = 4'd9;
    localparam t_op OP_GE   = 4'd10;
    localparam t_op OP_AND  = 4'd11;
    localparam t_op OP_OR   = 4'd12;
    localparam t_op OP_XOR  = 4'd13;
    localparam t_op OP_NOT  = 4'd14;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_UNDER = 2'd1;
    localparam t_status ST_OVER  = 2'd2;
    localparam t_status ST_DIVZ  = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
        logic div_commit;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
        logic last;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ----- rtl/core/pse_tok_if.sv -----
`default_nettype none
interface pse_tok_if;
    import pse_pkg::*;

    logic  valid;
    logic  ready;
    t_op   op;
    t_word operand;
    logic  last;

    modport source (output valid, output op, output operand, output last, input ready);
    modport sink (input valid, input op, input operand, input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/pse_res_if.sv -----
`default_nettype none
interface pse_res_if;
    import pse_pkg::*;

    logic    valid;
    logic    ready;
    t_word   value;
    t_status status;

    modport source (output valid, output value, output status, input ready);
    modport sink (input valid, input value, input status, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/pse_div.sv -----
`default_nettype none
module pse_div
    import pse_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_word i_a,
    input  wire t_word i_b,
    output logic       o_done,
    output t_word      o_quo
);

    localparam int CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_rem;
    t_word            r_quo;
    t_word            r_div;
    logic             r_neg;

    logic [WORD_W:0] w_shift;
    logic [WORD_W:0] w_diff;
    logic            w_fit;

    assign w_shift = {r_rem, r_quo[WORD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_fit   = (w_shift >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_a[WORD_W-1] ? (WORD_W'(0) - i_a) : i_a;
            r_div <= i_b[WORD_W-1] ? (WORD_W'(0) - i_b) : i_b;
            r_neg <= i_a[WORD_W-1] ^ i_b[WORD_W-1];
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[WORD_W-1:0] : w_shift[WORD_W-1:0];
            r_quo <= {r_quo[WORD_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? (WORD_W'(0) - r_quo) : r_quo;

endmodule
`default_nettype wire

// ----- rtl/core/pse_ctrl.sv -----
`default_nettype none
module pse_ctrl
    import pse_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_tok_valid,
    output logic         o_tok_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_tok_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.need_div) begin
                    n_state = S_DIV;
                end else if (i_sts.last) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_commit = 1'b1;
                    n_state = i_sts.last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_tok_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

// ----- rtl/core/pse_dp.sv -----
`default_nettype none
module pse_dp
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_op     i_op,
    input  wire t_word   i_operand,
    input  wire logic    i_last,
    input  wire t_dp_cmd i_cmd,
    output t_dp_sts      o_sts,
    input  wire logic    i_res_ready,
    output logic         o_res_valid,
    output t_word        o_res_value,
    output t_status      o_res_status
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [DW-1:0] DEPTH_ONE  = DW'(1);
    localparam logic [DW-1:0] DEPTH_TWO  = DW'(2);
    localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);

    // The top of stack lives in r_top; the entries below it live in r_stack.
    t_word r_stack [STACK_DEPTH];
    t_word r_top;
    t_word r_below;
    logic [DW-1:0] r_depth;
    t_status r_err;

    t_op  r_op;
    t_word r_operand;
    logic r_last;

    logic    r_out_valid;
    t_word   r_out_value;
    t_status r_out_status;

    t_word         n_top;
    logic [DW-1:0] n_depth;
    t_status       n_err;
    logic          w_wr_en;
    logic [DW-1:0] w_rd_idx;
    logic [DW-1:0] w_wr_idx;
    t_word         w_prod;
    t_word         w_alu;
    t_word         w_quo;
    logic          w_div_done;
    logic          w_is_bin;
    logic          w_has_two;
    logic          w_need_div;

    assign w_rd_idx   = r_depth - DEPTH_TWO;
    assign w_wr_idx   = r_depth - DEPTH_ONE;
    assign w_prod     = r_below * r_top;
    assign w_is_bin   = (r_op inside {[OP_ADD:OP_XOR]});
    assign w_has_two  = (r_depth >= DEPTH_TWO);
    assign w_need_div = (r_op == OP_DIV) && w_has_two && (r_top != '0);

    always_comb begin
        case (r_op)
            OP_ADD:  w_alu = r_below + r_top;
            OP_SUB:  w_alu = r_below - r_top;
            OP_MUL:  w_alu = w_prod;
            OP_EQ:   w_alu = WORD_W'(r_below == r_top);
            OP_NE:   w_alu = WORD_W'(r_below != r_top);
            OP_LT:   w_alu = WORD_W'($signed(r_below) < $signed(r_top));
            OP_GT:   w_alu = WORD_W'($signed(r_below) > $signed(r_top));
            OP_LE:   w_alu = WORD_W'($signed(r_below) <= $signed(r_top));
            OP_GE:   w_alu = WORD_W'($signed(r_below) >= $signed(r_top));
            OP_AND:  w_alu = r_below & r_top;
            OP_OR:   w_alu = r_below | r_top;
            OP_XOR:  w_alu = r_below ^ r_top;
            default: w_alu = '0;
        endcase
    end

    pse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.exec && w_need_div),
        .i_a     (r_below),
        .i_b     (r_top),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        n_top   = r_top;
        n_depth = r_depth;
        n_err   = r_err;
        w_wr_en = 1'b0;
        if (i_cmd.exec) begin
            if (r_op == OP_PUSH) begin
                if (r_depth >= DEPTH_FULL) begin
                    if (r_err == ST_OK) begin
                        n_err = ST_OVER;
                    end
                end else begin
                    w_wr_en = 1'b1;
                    n_top   = r_operand;
                    n_depth = r_depth + DEPTH_ONE;
                end
            end else if (w_is_bin) begin
                if (!w_has_two) begin
                    if (r_err == ST_OK) begin
                        n_err = ST_UNDER;
                    end
                end else if (r_op == OP_DIV) begin
                    if (r_top == '0) begin
                        if (r_err == ST_OK) begin
                            n_err = ST_DIVZ;
                        end
                        n_top   = '0;
                        n_depth = r_depth - DEPTH_ONE;
                    end
                end else begin
                    n_top   = w_alu;
                    n_depth = r_depth - DEPTH_ONE;
                end
            end else if (r_op == OP_NOT) begin
                n_top = ~r_top;
            end
        end else if (i_cmd.div_commit) begin
            n_top   = w_quo;
            n_depth = r_depth - DEPTH_ONE;
        end else if (i_cmd.emit) begin
            n_top   = '0;
            n_depth = DEPTH_ONE;
            n_err   = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_depth     <= DEPTH_ONE;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_top   <= n_top;
            r_depth <= n_depth;
            r_err   <= n_err;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_operand <= i_operand;
            r_last    <= i_last;
        end
        if (i_cmd.emit) begin
            r_out_value  <= (r_err == ST_OK) ? r_top : '0;
            r_out_status <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_stack[w_wr_idx[AW-1:0]] <= r_top;
        end
        if (i_cmd.load) begin
            r_below <= r_stack[w_rd_idx[AW-1:0]];
        end
    end

    assign o_sts.need_div = w_need_div;
    assign o_sts.last     = r_last;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid || i_res_ready;

    assign o_res_valid  = r_out_valid;
    assign o_res_value  = r_out_value;
    assign o_res_status = r_out_status;

endmodule
`default_nettype wire

// ----- rtl/core/postfix_stack_evaluator_unit.sv -----
// Postfix expression evaluator on a stack of signed 32-bit integers.
// Tokens arrive on i_tok (op, operand, last) and are taken when valid and
// ready are both high; ready is high only while the block waits for a token.
// A token marked last produces one request on o_res carrying the top of stack
// (zero on error) and a status code; other tokens produce nothing.
// Each accepted token is executed (EXEC state) before ready returns; a
// division of two entries by a nonzero divisor first runs through a
// one-bit-per-cycle divider (DIV). A last token then loads the result (EMIT).
// The result register holds its request until o_res.ready; if it is still
// full when the next result is due, the block waits without taking tokens,
// while the register frees itself as soon as the receiver takes it.
// After a result is loaded, the stack returns to a single zero entry and the
// status clears, so the next token starts a new expression.
// Reset (i_rst_n low, synchronous) empties the result register and sets the
// stack to a single zero entry; no clearing pass is needed.
// STACK_DEPTH sets the number of stack entries, from 2 to 256.
`default_nettype none
module postfix_stack_evaluator_unit
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    pse_tok_if.sink   i_tok,
    pse_res_if.source o_res
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    pse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (i_tok.valid),
        .o_tok_ready (i_tok.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    pse_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (i_tok.op),
        .i_operand    (i_tok.operand),
        .i_last       (i_tok.last),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_res_ready  (o_res.ready),
        .o_res_valid  (o_res.valid),
        .o_res_value  (o_res.value),
        .o_res_status (o_res.status)
    );

    a_emit_before_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(w_cmd.emit))
        else $error("result appeared without a load");

    a_error_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status != ST_OK)) |-> (o_res.value == '0))
        else $error("nonzero value with error status");

    a_div_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.div_done |-> !i_tok.ready)
        else $error("divider finished while idle");

endmodule
`default_nettype wire

// ----- sim/postfix_stack_evaluator_unit_tb.sv -----
`default_nettype none
module postfix_stack_evaluator_unit_tb;
    import pse_pkg::*;

    localparam int STACK_DEPTH   = 16;
    localparam int RANDOM_TOKENS = 1500;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT       = 40;
    localparam int MAX_REPORTS   = 10;

    localparam t_op   OP_SPARE  = 4'd15;
    localparam t_word WORD_MIN  = 32'h8000_0000;
    localparam t_word WORD_MAX  = 32'h7FFF_FFFF;
    localparam t_word WORD_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        t_word   value;
        t_status status;
    } t_result;

    typedef struct packed {
        t_op        op;
        t_word      operand;
        logic       last;
        logic [4:0] count;
        logic       typed;
        t_result    want;
    } t_row;

    localparam int N_ROWS = 35;
    localparam t_row DIRECTED [N_ROWS] = '{
        '{OP_SPARE, 32'd0,         1'b1, 5'd1,  1'b1, '{32'd0, ST_OK}},
        '{OP_ADD,   32'd0,         1'b1, 5'd1,  1'b1, '{32'd0, ST_UNDER}},
        '{OP_NOT,   32'd0,         1'b1, 5'd1,  1'b1, '{WORD_ONES, ST_OK}},
        '{OP_PUSH,  32'd12345,     1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_PUSH,  32'd0,         1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_DIV,   32'd0,         1'b1, 5'd1,  1'b1, '{32'd0, ST_DIVZ}},
        '{OP_PUSH,  WORD_MIN,      1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_PUSH,  WORD_ONES,     1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_DIV,   32'd0,         1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_PUSH,  32'd1,         1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_SUB,   32'd0,         1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_PUSH,  32'hFFFF_FFFE, 1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_MUL,   32'd0,         1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_PUSH,  WORD_MAX,      1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_ADD,   32'd0,         1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_PUSH,  32'h8000_0001, 1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_EQ,    32'd0,         1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_PUSH,  32'd0,         1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_NE,    32'd0,         1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_PUSH,  WORD_MIN,      1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_LT,    32'd0,         1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_PUSH,  WORD_ONES,     1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_GT,    32'd0,         1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_PUSH,  WORD_MAX,      1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_LE,    32'd0,         1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_PUSH,  WORD_MIN,      1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_GE,    32'd0,         1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_PUSH,  32'h0F0F_0F0F, 1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_AND,   32'd0,         1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_PUSH,  32'hF000_0000, 1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_OR,    32'd0,         1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_PUSH,  32'h5A5A_5A5A, 1'b0, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_XOR,   32'd0,         1'b1, 5'd1,  1'b0, '{32'd0, ST_OK}},
        '{OP_PUSH,  WORD_MAX,      1'b0, 5'd15, 1'b0, '{32'd0, ST_OK}},
        '{OP_PUSH,  WORD_MIN,      1'b1, 5'd1,  1'b1, '{32'd0, ST_OVER}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    pse_tok_if tok_bus ();
    pse_res_if res_bus ();

    postfix_stack_evaluator_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tok  (tok_bus),
        .o_res  (res_bus)
    );

    t_word       eval_stack [STACK_DEPTH];
    int          eval_depth;
    t_status     eval_error;
    t_result     pending_results [$];
    int unsigned mismatches;
    int unsigned results_seen;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin : reset_gen
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic void clear_stack();
        foreach (eval_stack[i]) begin
            eval_stack[i] = '0;
        end
        eval_depth = 1;
        eval_error = ST_OK;
    endfunction

    function automatic void flag_error(t_status code);
        if (eval_error == ST_OK) begin
            eval_error = code;
        end
    endfunction

    // Division truncates toward zero on the magnitudes, so the most negative
    // value divided by minus one wraps back to itself.
    function automatic t_word quotient(t_word a, t_word b);
        t_word ma;
        t_word mb;
        t_word q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic t_word combine(t_op op, t_word a, t_word b);
        case (op)
            OP_ADD: return a + b;
            OP_SUB: return a - b;
            OP_MUL: return a * b;
            OP_DIV: return quotient(a, b);
            OP_EQ:  return t_word'(a == b);
            OP_NE:  return t_word'(a != b);
            OP_LT:  return t_word'($signed(a) < $signed(b));
            OP_GT:  return t_word'($signed(a) > $signed(b));
            OP_LE:  return t_word'($signed(a) <= $signed(b));
            OP_GE:  return t_word'($signed(a) >= $signed(b));
            OP_AND: return a & b;
            OP_OR:  return a | b;
            default: return a ^ b;
        endcase
    endfunction

    function automatic void evaluate_token(t_op op, t_word operand, logic last,
                                           output logic made, output t_result res);
        t_word a;
        t_word b;
        t_word r;
        made = 1'b0;
        res  = '0;
        if (op == OP_PUSH) begin
            if (eval_depth >= STACK_DEPTH) begin
                flag_error(ST_OVER);
            end else begin
                eval_stack[eval_depth] = operand;
                eval_depth++;
            end
        end else if (op >= OP_ADD && op <= OP_XOR) begin
            if (eval_depth < 2) begin
                flag_error(ST_UNDER);
            end else begin
                b = eval_stack[eval_depth-1];
                a = eval_stack[eval_depth-2];
                if (op == OP_DIV && b == '0) begin
                    flag_error(ST_DIVZ);
                    r = '0;
                end else begin
                    r = combine(op, a, b);
                end
                eval_depth--;
                eval_stack[eval_depth-1] = r;
            end
        end else if (op == OP_NOT) begin
            eval_stack[eval_depth-1] = ~eval_stack[eval_depth-1];
        end
        if (last) begin
            made       = 1'b1;
            res.status = eval_error;
            res.value  = (eval_error == ST_OK) ? eval_stack[eval_depth-1] : '0;
            clear_stack();
        end
    endfunction

    function automatic void log_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void check_result(t_word value, t_status status);
        t_result want;
        results_seen++;
        if (pending_results.size() == 0) begin
            log_mismatch($sformatf("Unexpected result request: value %0d status %0d",
                                   $signed(value), status));
            return;
        end
        want = pending_results.pop_front();
        if (value !== want.value || status !== want.status) begin
            log_mismatch($sformatf(
                "Result request %0d: value %0d status %0d, expected value %0d status %0d",
                results_seen, $signed(value), status, $signed(want.value), want.status));
        end
    endfunction

    function automatic int pick_gap(bit burst);
        int roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 55) begin
            return 0;
        end else if (roll < 88) begin
            return $urandom_range(1, 3);
        end else if (roll < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_word pick_word();
        case ($urandom_range(0, 9))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return WORD_ONES;
            4, 5: return $urandom_range(0, 16) - 32'd8;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_op pick_operation();
        if ($urandom_range(0, 9) == 0) begin
            return OP_NOT;
        end
        return t_op'($urandom_range(OP_ADD, OP_XOR));
    endfunction

    task automatic send_token(input t_op op, input t_word operand, input logic last,
                              input logic typed, input t_result want, input int gap);
        logic    made;
        t_result predicted;
        if (gap > 0) begin
            tok_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tok_bus.valid   <= 1'b1;
        tok_bus.op      <= op;
        tok_bus.operand <= operand;
        tok_bus.last    <= last;
        do @(posedge i_clk); while (!tok_bus.ready);
        evaluate_token(op, operand, last, made, predicted);
        if (made) begin
            pending_results.push_back(typed ? want : predicted);
        end
    endtask

    task automatic wait_drained();
        tok_bus.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin : token_source
        int  sent;
        int  peak;
        int  pushes;
        int  n_noise;
        bit  burst;
        bit  paused;
        bit  done;
        bit  last;
        t_op op;
        tok_bus.valid   <= 1'b0;
        tok_bus.op      <= OP_PUSH;
        tok_bus.operand <= '0;
        tok_bus.last    <= 1'b0;
        mismatches   = 0;
        results_seen = 0;
        clear_stack();
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        foreach (DIRECTED[r]) begin
            for (int k = 0; k < DIRECTED[r].count; k++) begin
                send_token(DIRECTED[r].op, DIRECTED[r].operand, DIRECTED[r].last,
                           DIRECTED[r].typed, DIRECTED[r].want, pick_gap(1'b0));
            end
        end
        wait_drained();

        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_TOKENS) begin
            if (!paused && sent >= RANDOM_TOKENS / 2) begin
                paused = 1'b1;
                wait_drained();
            end
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 80) begin
                // A well-formed expression; now and then it pushes past a full stack.
                peak   = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 19)
                                                     : $urandom_range(1, 6);
                pushes = 0;
                done   = 1'b0;
                while (!done) begin
                    if (pushes < peak && (eval_depth < 2 || $urandom_range(0, 2) != 0)) begin
                        op = OP_PUSH;
                        pushes++;
                    end else begin
                        op = pick_operation();
                    end
                    done = (pushes >= peak && op != OP_PUSH && eval_depth <= 2);
                    send_token(op, pick_word(), done, 1'b0, '0, pick_gap(burst));
                    sent++;
                end
            end else begin
                n_noise = $urandom_range(1, 6);
                for (int k = 0; k < n_noise; k++) begin
                    op   = t_op'($urandom_range(0, 15));
                    last = (k == n_noise - 1) || ($urandom_range(0, 7) == 0);
                    send_token(op, pick_word(), last, 1'b0, '0, pick_gap(burst));
                    if (op != OP_SPARE || last) begin
                        sent++;
                    end
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : result_sink
        int idle_left;
        int calm_left;
        int roll;
        bit held_off;
        res_bus.ready <= 1'b0;
        idle_left = 0;
        calm_left = 0;
        held_off  = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (res_bus.valid && res_bus.ready) begin
                check_result(res_bus.value, res_bus.status);
            end
            // One long stall lets the result register fill and blocks new tokens.
            if (!held_off && results_seen >= HOLD_AT) begin
                held_off  = 1'b1;
                idle_left = HOLD_CYCLES;
            end
            if (idle_left > 0) begin
                idle_left--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 5) begin
                        calm_left = $urandom_range(50, 200);
                    end else if (roll < 40) begin
                        idle_left = $urandom_range(1, 3);
                    end else if (roll < 44) begin
                        idle_left = $urandom_range(10, 60);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
